// ===== rtl/plm_pkg.sv =====
// Shared types and codes for the PCR pair latency monitor.
`default_nettype none

package plm_pkg;

  localparam int PCR_W  = 42;
  localparam int TIME_W = 48;
  localparam int WIN_W  = 40;

  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(27000000);

  typedef enum logic [1:0] {
    FUNC_PKT_A  = 2'd0,
    FUNC_PKT_B  = 2'd1,
    FUNC_REPORT = 2'd2,
    FUNC_UNUSED = 2'd3
  } func_t;

  typedef enum logic [10:0] {
    ST_IDLE    = 11'b000_0000_0001,
    ST_EXP_RD  = 11'b000_0000_0010,
    ST_EXP_CMP = 11'b000_0000_0100,
    ST_WRITE   = 11'b000_0000_1000,
    ST_R_CAP   = 11'b000_0001_0000,
    ST_S_RD    = 11'b000_0010_0000,
    ST_S_CMP   = 11'b000_0100_0000,
    ST_LAT1    = 11'b000_1000_0000,
    ST_LAT2    = 11'b001_0000_0000,
    ST_PEAK    = 11'b010_0000_0000,
    ST_EMIT    = 11'b100_0000_0000
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/pcr_pair_latency_monitor.sv =====
// PCR pair latency monitor: two PCR windows, expiry, search and latency report.
//
//   channel | signals                      | direction | carries
//   --------+------------------------------+-----------+-------------------------------
//   input   | in_valid, in_stall           | in        | func, has_pcr, pcr, arrival_time
//   output  | out_valid, out_stall         | out       | matched .. max_latency_ticks
//   config  | cfg_wr_en, cfg_wr_data       | in        | window_ticks
//
// A packet with a PCR examines the oldest entries of its stream for expiry; each examined
// entry costs one memory read and one subtract, then the packet is written. Other packets,
// unused codes and reports with both stores empty finish in the idle state. A report
// captures both newest entries, searches if both stores hold entries (one read and one
// compare per entry), on a match computes latency and peak, then waits while out is stalled.
// Reset clears counts, pointers and the peak and loads the window default; no clearing pass.
`default_nettype none

module pcr_pair_latency_monitor
  import plm_pkg::*;
#(
  parameter int WINDOW_DEPTH = 256
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          func,
  input  wire logic                has_pcr,
  input  wire logic [PCR_W-1:0]    pcr,
  input  wire logic [TIME_W-1:0]   arrival_time,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic                     matched,
  output logic                     a_present,
  output logic                     b_present,
  output logic [PCR_W-1:0]         pcr_a,
  output logic [PCR_W-1:0]         pcr_b,
  output logic [TIME_W-1:0]        latency_ticks,
  output logic [TIME_W-1:0]        max_latency_ticks,
  input  wire logic                cfg_wr_en,
  input  wire logic [WIN_W-1:0]    cfg_wr_data
);

  localparam int IDX_W = $clog2(WINDOW_DEPTH);
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(WINDOW_DEPTH);

  // Storage.
  logic [PCR_W-1:0]  a_pcr_mem  [WINDOW_DEPTH];
  logic [TIME_W-1:0] a_time_mem [WINDOW_DEPTH];
  logic [PCR_W-1:0]  b_pcr_mem  [WINDOW_DEPTH];
  logic [TIME_W-1:0] b_time_mem [WINDOW_DEPTH];
  logic [PCR_W-1:0]  a_pcr_q, b_pcr_q;
  logic [TIME_W-1:0] a_time_q, b_time_q;
  logic [IDX_W-1:0]  a_raddr, b_raddr;

  // Control and window state.
  state_t            state;
  logic [WIN_W-1:0]  window_ticks;
  logic [IDX_W-1:0]  a_newest, b_newest, a_oldest, b_oldest;
  logic [CNT_W-1:0]  a_cnt, b_cnt;
  logic [TIME_W-1:0] peak;

  // Working registers of the current request.
  logic              strm_b;
  logic [PCR_W-1:0]  pkt_pcr;
  logic [TIME_W-1:0] pkt_time;
  logic              ap, bp, a_is_ref, pass, matched_r;
  logic [PCR_W-1:0]  res_pcr_a, res_pcr_b;
  logic [TIME_W-1:0] ta, tb, other_t, lat;
  logic [IDX_W-1:0]  scan_idx;
  logic [CNT_W-1:0]  scan_k;

  // Shared subtractor.
  logic [TIME_W-1:0] sub_x, sub_y;
  logic [TIME_W:0]   sub_res;
  logic              borrow;

  // Selected-stream and search views.
  logic [CNT_W-1:0]  s_cnt, oth_cnt, scan_k_next;
  logic [IDX_W-1:0]  s_newest, s_oldest, s_newest_inc, s_oldest_inc;
  logic [TIME_W-1:0] s_time_q, oth_time_q, ref_t;
  logic [PCR_W-1:0]  oth_pcr_q, key;
  logic              expire, hit;
  logic [CNT_W-1:0]  exp_cnt;
  logic              emit_fire;

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
    idx_inc = (idx == LAST_IDX) ? '0 : idx + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] idx);
    idx_dec = (idx == '0) ? LAST_IDX : idx - 1'b1;
  endfunction

  assign in_stall = (state != ST_IDLE);

  assign s_cnt        = strm_b ? b_cnt : a_cnt;
  assign s_newest     = strm_b ? b_newest : a_newest;
  assign s_oldest     = strm_b ? b_oldest : a_oldest;
  assign s_time_q     = strm_b ? b_time_q : a_time_q;
  assign s_newest_inc = idx_inc(s_newest);
  assign s_oldest_inc = idx_inc(s_oldest);
  assign exp_cnt      = s_cnt - 1'b1;

  // When A is the reference the search runs over store B, and the other way round.
  assign oth_cnt     = a_is_ref ? b_cnt : a_cnt;
  assign oth_pcr_q   = a_is_ref ? b_pcr_q : a_pcr_q;
  assign oth_time_q  = a_is_ref ? b_time_q : a_time_q;
  assign key         = a_is_ref ? res_pcr_a : res_pcr_b;
  assign ref_t       = a_is_ref ? ta : tb;
  assign hit         = (oth_pcr_q == key);
  assign scan_k_next = scan_k + 1'b1;

  // A result moves to the output register when that register is free or being taken.
  assign emit_fire   = (state == ST_EMIT) && (!out_valid || !out_stall);

  always_comb begin
    sub_x = '0;
    sub_y = '0;
    unique case (state)
      ST_EXP_CMP: begin
        sub_x = pkt_time;
        sub_y = s_time_q;
      end
      ST_R_CAP: begin
        sub_x = TIME_W'(b_pcr_q);
        sub_y = TIME_W'(a_pcr_q);
      end
      ST_LAT1: begin
        sub_x = ref_t;
        sub_y = other_t;
      end
      ST_LAT2: begin
        sub_x = other_t;
        sub_y = ref_t;
      end
      ST_PEAK: begin
        sub_x = peak;
        sub_y = lat;
      end
      default: begin
        sub_x = '0;
        sub_y = '0;
      end
    endcase
  end

  assign sub_res = {1'b0, sub_x} - {1'b0, sub_y};
  assign borrow  = sub_res[TIME_W];
  assign expire  = !borrow && (sub_res[TIME_W-1:0] >= TIME_W'(window_ticks));

  // Read addresses: oldest during expiry, scan pointer during a search, else newest.
  always_comb begin
    a_raddr = a_newest;
    b_raddr = b_newest;
    if (state == ST_EXP_RD) begin
      a_raddr = a_oldest;
      b_raddr = b_oldest;
    end else if (state == ST_S_RD) begin
      a_raddr = scan_idx;
      b_raddr = scan_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_WRITE && !strm_b) begin
      a_pcr_mem[s_newest_inc]  <= pkt_pcr;
      a_time_mem[s_newest_inc] <= pkt_time;
    end
    if (state == ST_WRITE && strm_b) begin
      b_pcr_mem[s_newest_inc]  <= pkt_pcr;
      b_time_mem[s_newest_inc] <= pkt_time;
    end
    a_pcr_q  <= a_pcr_mem[a_raddr];
    a_time_q <= a_time_mem[a_raddr];
    b_pcr_q  <= b_pcr_mem[b_raddr];
    b_time_q <= b_time_mem[b_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_ticks <= WINDOW_RESET;
    end else if (cfg_wr_en) begin
      window_ticks <= cfg_wr_data;
    end
  end

  // Payload registers of the request; no reset needed.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      strm_b   <= (func_t'(func) == FUNC_PKT_B);
      pkt_pcr  <= pcr;
      pkt_time <= arrival_time;
    end
    unique case (state)
      ST_R_CAP: begin
        ap        <= (a_cnt != '0);
        bp        <= (b_cnt != '0);
        res_pcr_a <= (a_cnt != '0) ? a_pcr_q : '0;
        res_pcr_b <= (b_cnt != '0) ? b_pcr_q : '0;
        ta        <= a_time_q;
        tb        <= b_time_q;
        // b_pcr - a_pcr borrows exactly when A's newest PCR is the larger.
        a_is_ref  <= !borrow;
        pass      <= 1'b0;
        scan_k    <= '0;
        scan_idx  <= borrow ? a_newest : b_newest;
        matched_r <= 1'b0;
        lat       <= '0;
      end
      ST_S_CMP: begin
        if (hit) begin
          other_t <= oth_time_q;
        end else if (scan_k_next == oth_cnt) begin
          pass     <= 1'b1;
          a_is_ref <= !a_is_ref;
          scan_k   <= '0;
          scan_idx <= a_is_ref ? a_newest : b_newest;
        end else begin
          scan_k   <= scan_k_next;
          scan_idx <= idx_dec(scan_idx);
        end
      end
      ST_LAT1: begin
        lat <= sub_res[TIME_W-1:0];
      end
      ST_LAT2: begin
        lat <= sub_res[TIME_W-1:0];
      end
      ST_PEAK: begin
        matched_r <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      a_newest  <= '0;
      b_newest  <= '0;
      a_oldest  <= '0;
      b_oldest  <= '0;
      a_cnt     <= '0;
      b_cnt     <= '0;
      peak      <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            unique case (func_t'(func))
              FUNC_PKT_A: begin
                if (has_pcr) state <= (a_cnt != '0) ? ST_EXP_RD : ST_WRITE;
              end
              FUNC_PKT_B: begin
                if (has_pcr) state <= (b_cnt != '0) ? ST_EXP_RD : ST_WRITE;
              end
              FUNC_REPORT: begin
                // The newest entries are already being read at this edge.
                if (a_cnt != '0 || b_cnt != '0) state <= ST_R_CAP;
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_EXP_RD: begin
          state <= ST_EXP_CMP;
        end
        ST_EXP_CMP: begin
          if (expire) begin
            if (strm_b) begin
              b_cnt    <= exp_cnt;
              b_oldest <= s_oldest_inc;
            end else begin
              a_cnt    <= exp_cnt;
              a_oldest <= s_oldest_inc;
            end
            state <= (exp_cnt != '0) ? ST_EXP_RD : ST_WRITE;
          end else begin
            state <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          // A full store drops its oldest entry to make room.
          if (strm_b) begin
            b_newest <= s_newest_inc;
            if (b_cnt == FULL_CNT) begin
              b_oldest <= s_oldest_inc;
            end else begin
              b_cnt <= b_cnt + 1'b1;
              if (b_cnt == '0) b_oldest <= s_newest_inc;
            end
          end else begin
            a_newest <= s_newest_inc;
            if (a_cnt == FULL_CNT) begin
              a_oldest <= s_oldest_inc;
            end else begin
              a_cnt <= a_cnt + 1'b1;
              if (a_cnt == '0) a_oldest <= s_newest_inc;
            end
          end
          state <= ST_IDLE;
        end
        ST_R_CAP: begin
          state <= (a_cnt != '0 && b_cnt != '0) ? ST_S_RD : ST_EMIT;
        end
        ST_S_RD: begin
          state <= ST_S_CMP;
        end
        ST_S_CMP: begin
          if (hit) begin
            state <= ST_LAT1;
          end else if (scan_k_next == oth_cnt && pass) begin
            state <= ST_EMIT;
          end else begin
            state <= ST_S_RD;
          end
        end
        ST_LAT1: begin
          state <= borrow ? ST_LAT2 : ST_PEAK;
        end
        ST_LAT2: begin
          state <= ST_PEAK;
        end
        ST_PEAK: begin
          if (borrow) peak <= lat;
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit_fire) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      matched           <= matched_r;
      a_present         <= ap;
      b_present         <= bp;
      pcr_a             <= matched_r ? key : res_pcr_a;
      pcr_b             <= matched_r ? key : res_pcr_b;
      latency_ticks     <= lat;
      max_latency_ticks <= peak;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (a_cnt <= FULL_CNT) && (b_cnt <= FULL_CNT))
    else $error("entry count exceeds window depth");

  scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_S_CMP) |-> (scan_k < oth_cnt))
    else $error("search ran past the stored entries");

  peak_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (peak >= $past(peak)))
    else $error("peak latency decreased");

  result_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_EMIT))
    else $error("result raised outside the emit step");

  match_same_pcr: assert property (@(posedge clk) disable iff (rst)
    (out_valid && matched) |-> (pcr_a == pcr_b && a_present && b_present))
    else $error("matched result with differing PCRs");
`endif

endmodule

`default_nettype wire

// ===== test/pcr_pair_latency_monitor_tb.sv =====
// Self-checking testbench for the PCR pair latency monitor, with a prediction scoreboard.
module pcr_pair_latency_monitor_tb;
  import plm_pkg::*;

  localparam int WINDOW_DEPTH = 256;
  localparam logic [PCR_W-1:0] PCR_MAX = 42'd2576980377599;
  localparam int SETTLE_CYCLES = 1100;
  localparam int CYCLE_LIMIT = 4000000;

  typedef struct packed {
    logic matched;
    logic a_present;
    logic b_present;
    logic [PCR_W-1:0] pcr_a;
    logic [PCR_W-1:0] pcr_b;
    logic [TIME_W-1:0] latency;
    logic [TIME_W-1:0] peak;
  } report_t;

  // Mirrors both PCR windows and predicts every report, then checks it on arrival.
  class latency_scoreboard;
    logic [WIN_W-1:0] window;
    logic [PCR_W-1:0] pcr_mem[2][WINDOW_DEPTH];
    logic [TIME_W-1:0] time_mem[2][WINDOW_DEPTH];
    int unsigned newest[2];
    int unsigned count[2];
    logic [TIME_W-1:0] peak;
    report_t expected_q[$];
    int errors, n_requests, n_reports, n_matched, n_expired, n_full;

    function new();
      window = WINDOW_RESET;
      newest = '{0, 0};
      count = '{0, 0};
      peak = '0;
      errors = 0;
      n_requests = 0;
      n_reports = 0;
      n_matched = 0;
      n_expired = 0;
      n_full = 0;
    endfunction

    function void set_window(logic [WIN_W-1:0] w);
      window = w;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function int unsigned slot_back(int unsigned s, int unsigned k);
      return (s + WINDOW_DEPTH - k) % WINDOW_DEPTH;
    endfunction

    function void store_pair(int s, logic [PCR_W-1:0] p, logic [TIME_W-1:0] t);
      int unsigned oldest;
      logic [TIME_W-1:0] age;
      // An entry stamped later than the new arrival never counts as aged out.
      while (count[s] > 0) begin
        oldest = slot_back(newest[s], count[s] - 1);
        age = t - time_mem[s][oldest];
        if (t >= time_mem[s][oldest] && age >= TIME_W'(window)) begin
          count[s]--;
          n_expired++;
        end else begin
          break;
        end
      end
      if (count[s] >= WINDOW_DEPTH) begin
        count[s] = WINDOW_DEPTH - 1;
        n_full++;
      end
      newest[s] = (newest[s] + 1) % WINDOW_DEPTH;
      pcr_mem[s][newest[s]] = p;
      time_mem[s][newest[s]] = t;
      count[s]++;
    endfunction

    function bit find_pcr(int s, logic [PCR_W-1:0] key, output logic [TIME_W-1:0] found_time);
      int unsigned k;
      int unsigned slot;
      found_time = '0;
      for (k = 0; k < count[s]; k++) begin
        slot = slot_back(newest[s], k);
        if (pcr_mem[s][slot] == key) begin
          found_time = time_mem[s][slot];
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void predict_report();
      report_t r;
      bit a_first, a_is_key, hit;
      int attempt;
      logic [PCR_W-1:0] key;
      logic [TIME_W-1:0] ta, tb, key_time, other_time, lat;
      if (count[0] == 0 && count[1] == 0) return;
      r = '0;
      r.a_present = count[0] > 0;
      r.b_present = count[1] > 0;
      r.pcr_a = r.a_present ? pcr_mem[0][newest[0]] : '0;
      r.pcr_b = r.b_present ? pcr_mem[1][newest[1]] : '0;
      r.peak = peak;
      if (r.a_present && r.b_present) begin
        ta = time_mem[0][newest[0]];
        tb = time_mem[1][newest[1]];
        // The smaller newest PCR is looked up first; on a tie stream A leads.
        a_first = !(r.pcr_a > r.pcr_b);
        for (attempt = 0; attempt < 2 && !r.matched; attempt++) begin
          a_is_key = (attempt == 0) ? a_first : !a_first;
          key = a_is_key ? r.pcr_a : r.pcr_b;
          key_time = a_is_key ? ta : tb;
          hit = find_pcr(a_is_key ? 1 : 0, key, other_time);
          if (hit) begin
            lat = (key_time >= other_time) ? key_time - other_time : other_time - key_time;
            if (lat > peak) peak = lat;
            r.matched = 1'b1;
            r.pcr_a = key;
            r.pcr_b = key;
            r.latency = lat;
            r.peak = peak;
          end
        end
      end
      expected_q = {expected_q, r};
    endfunction

    function void note_request(func_t f, logic has, logic [PCR_W-1:0] p, logic [TIME_W-1:0] t);
      n_requests++;
      case (f)
        FUNC_PKT_A: if (has) store_pair(0, p, t);
        FUNC_PKT_B: if (has) store_pair(1, p, t);
        FUNC_REPORT: predict_report();
        default: ;
      endcase
    endfunction

    function void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_report(report_t got);
      report_t want;
      n_reports++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: report with nothing expected, actual matched %0b pcr_a %0h pcr_b %0h",
                 $time, got.matched, got.pcr_a, got.pcr_b);
        return;
      end
      want = expected_q.pop_front();
      if (want.matched) n_matched++;
      check_field("matched", 64'(want.matched), 64'(got.matched));
      check_field("a_present", 64'(want.a_present), 64'(got.a_present));
      check_field("b_present", 64'(want.b_present), 64'(got.b_present));
      check_field("pcr_a", 64'(want.pcr_a), 64'(got.pcr_a));
      check_field("pcr_b", 64'(want.pcr_b), 64'(got.pcr_b));
      check_field("latency_ticks", 64'(want.latency), 64'(got.latency));
      check_field("max_latency_ticks", 64'(want.peak), 64'(got.peak));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] func = FUNC_PKT_A;
  logic has_pcr = 1'b0;
  logic [PCR_W-1:0] pcr = '0;
  logic [TIME_W-1:0] arrival_time = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic matched, a_present, b_present;
  logic [PCR_W-1:0] pcr_a, pcr_b;
  logic [TIME_W-1:0] latency_ticks, max_latency_ticks;
  logic cfg_wr_en = 1'b0;
  logic [WIN_W-1:0] cfg_wr_data = '0;

  latency_scoreboard sb;
  int send_idle_pct = 18;
  int recv_idle_pct = 76;
  int cycle_count = 0;
  logic [TIME_W-1:0] now_time;
  logic [PCR_W-1:0] pcr_seq, last_pcr;
  logic [PCR_W-1:0] b_pcr_q[$];
  logic [TIME_W-1:0] b_time_q[$];

  pcr_pair_latency_monitor #(.WINDOW_DEPTH(WINDOW_DEPTH)) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .func(func),
    .has_pcr(has_pcr),
    .pcr(pcr),
    .arrival_time(arrival_time),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .matched(matched),
    .a_present(a_present),
    .b_present(b_present),
    .pcr_a(pcr_a),
    .pcr_b(pcr_b),
    .latency_ticks(latency_ticks),
    .max_latency_ticks(max_latency_ticks),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: check what is taken at this edge, then pick the stall for the next one.
  always @(posedge clk) begin
    cycle_count++;
    if (!rst && out_valid && !out_stall)
      sb.check_report(report_t'{matched, a_present, b_present, pcr_a, pcr_b,
                                latency_ticks, max_latency_ticks});
    out_stall <= !rst && ($urandom_range(0, 99) < recv_idle_pct);
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [TIME_W-1:0] rand48();
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    return v[TIME_W-1:0];
  endfunction

  function automatic logic [PCR_W-1:0] rand_pcr();
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    v = v % (64'(PCR_MAX) + 64'd1);
    return v[PCR_W-1:0];
  endfunction

  function automatic logic [TIME_W-1:0] rand_upto(logic [TIME_W-1:0] limit);
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    v = v % (64'(limit) + 64'd1);
    return v[TIME_W-1:0];
  endfunction

  function automatic logic [PCR_W-1:0] next_pcr(logic [PCR_W-1:0] p);
    logic [63:0] v;
    v = (64'(p) + 64'd1 + 64'($urandom_range(0, 3000))) % (64'(PCR_MAX) + 64'd1);
    return v[PCR_W-1:0];
  endfunction

  // Valid stays high from one request to the next unless an idle cycle falls between.
  task automatic send_request(func_t f, logic has, logic [PCR_W-1:0] p,
                              logic [TIME_W-1:0] t);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    has_pcr <= has;
    pcr <= p;
    arrival_time <= t;
    do @(posedge clk); while (in_stall);
    sb.note_request(f, has, p, t);
  endtask

  task automatic settle_block();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    // A packet request leaves no result, so give its expiry walk time to finish.
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(logic [WIN_W-1:0] w);
    settle_block();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= w;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_window(w);
  endtask

  // Mostly A/B packets carrying the same PCR with a skewed arrival, plus reports and noise.
  task automatic run_traffic(int unsigned n_items, logic [TIME_W-1:0] step_max);
    int unsigned done, roll;
    logic [TIME_W-1:0] skew;
    done = 0;
    while (done < n_items) begin
      roll = $urandom_range(0, 99);
      now_time = now_time + rand_upto(step_max);
      if (roll < 35) begin
        send_request(FUNC_PKT_A, 1'b1, pcr_seq, now_time);
        skew = rand_upto(step_max);
        b_pcr_q = {b_pcr_q, pcr_seq};
        b_time_q = {b_time_q, ($urandom_range(0, 1) ? now_time + skew : now_time - skew)};
        last_pcr = pcr_seq;
        pcr_seq = next_pcr(pcr_seq);
        done++;
      end else if (roll < 65) begin
        if (b_pcr_q.size() > 0)
          send_request(FUNC_PKT_B, 1'b1, b_pcr_q.pop_front(), b_time_q.pop_front());
        else
          send_request(FUNC_PKT_B, 1'b1, rand_pcr(), now_time);
        done++;
      end else if (roll < 80) begin
        send_request(FUNC_REPORT, 1'($urandom_range(0, 1)), rand_pcr(), rand48());
        done++;
      end else if (roll < 86) begin
        send_request($urandom_range(0, 1) ? FUNC_PKT_B : FUNC_PKT_A, 1'b1, rand_pcr(),
                     ($urandom_range(0, 3) == 0) ? rand48() : now_time);
        done++;
      end else if (roll < 90) begin
        send_request($urandom_range(0, 1) ? FUNC_PKT_B : FUNC_PKT_A, 1'b1, last_pcr,
                     now_time);
        done++;
      end else if (roll < 96) begin
        send_request($urandom_range(0, 1) ? FUNC_PKT_B : FUNC_PKT_A, 1'b0, rand_pcr(),
                     rand48());
        done++;
      end else begin
        send_request(FUNC_UNUSED, 1'($urandom_range(0, 1)), rand_pcr(), rand48());
        done++;
      end
    end
  endtask

  initial begin
    int unsigned k;
    logic [63:0] wide;
    logic [WIN_W-1:0] rand_window;
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part under the reset window.
    send_request(FUNC_REPORT, 1'b0, '0, '0);
    send_request(FUNC_UNUSED, 1'b1, PCR_MAX, '1);
    send_request(FUNC_PKT_A, 1'b0, 42'h155, 48'h10);
    send_request(FUNC_PKT_B, 1'b0, PCR_MAX, '1);
    send_request(FUNC_REPORT, 1'b1, PCR_MAX, '1);
    send_request(FUNC_PKT_B, 1'b1, '0, '0);
    send_request(FUNC_REPORT, 1'b0, '0, '0);
    send_request(FUNC_PKT_A, 1'b1, PCR_MAX, 48'd1000);
    send_request(FUNC_REPORT, 1'b0, '0, '0);
    send_request(FUNC_PKT_B, 1'b1, PCR_MAX, '1);
    send_request(FUNC_REPORT, 1'b0, '0, '0);
    // The B arrival below is earlier than the stored one, which must stay.
    send_request(FUNC_PKT_A, 1'b1, 42'd5, 48'd2000);
    send_request(FUNC_PKT_B, 1'b1, 42'd5, 48'd1500);
    send_request(FUNC_REPORT, 1'b0, '0, '0);
    // First lookup misses, the swapped lookup finds the pair.
    send_request(FUNC_PKT_B, 1'b1, 42'd100, 48'd3000);
    send_request(FUNC_PKT_A, 1'b1, 42'd100, 48'd3100);
    send_request(FUNC_PKT_B, 1'b1, 42'd50, 48'd3200);
    send_request(FUNC_REPORT, 1'b0, '0, '0);

    now_time = rand48();
    pcr_seq = rand_pcr();
    last_pcr = pcr_seq;
    write_window('0);
    run_traffic(80, 48'd1000);

    // Nothing expires, so a long run of stream A packets overflows its window.
    write_window('1);
    for (k = 0; k < 270; k++) begin
      now_time = now_time + rand_upto(48'd50);
      send_request(FUNC_PKT_A, 1'b1, pcr_seq, now_time);
      b_pcr_q = {b_pcr_q, pcr_seq};
      b_time_q = {b_time_q, (now_time + rand_upto(48'd200))};
      last_pcr = pcr_seq;
      pcr_seq = next_pcr(pcr_seq);
    end
    run_traffic(40, 48'd1000);

    send_idle_pct = 76;
    recv_idle_pct = 18;
    write_window(40'd5000);
    run_traffic(150, 48'd625);
    wide = {$urandom(), $urandom()};
    rand_window = wide[WIN_W-1:0];
    write_window(rand_window);
    run_traffic(120, TIME_W'(rand_window >> 3) + 48'd1);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_window(WINDOW_RESET);
    run_traffic(150, 48'd3375000);
    write_window(40'd1);
    run_traffic(60, 48'd2);

    settle_block();
    $display("Run covered %0d accepted requests over six window settings and %0d reports,",
             sb.n_requests, sb.n_reports);
    $display("%0d of them matched; %0d entries aged out, %0d pushed out of a full window.",
             sb.n_matched, sb.n_expired, sb.n_full);
    if (sb.errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/plm_pkg.sv
rtl/pcr_pair_latency_monitor.sv
test/pcr_pair_latency_monitor_tb.sv
